FILE: hdl/vph_pkg.sv
// package for the visited page hash set
// table geometry, hash constants and the command and result transaction types
`timescale 1ns / 1ps
`default_nettype none

package vph_pkg;

    localparam int SLOT_COUNT_LOG2 = 12;
    localparam int SLOT_COUNT      = 1 << SLOT_COUNT_LOG2;
    localparam int ADDR_W          = 64;
    localparam int PAGE_SHIFT      = 12;
    localparam int PAGE_W          = ADDR_W - PAGE_SHIFT;
    localparam int HASH_SHIFT      = 40;
    localparam int HALF_W          = 32;

    localparam logic [ADDR_W-1:0] FIB_MULT = 64'h9E37_79B9_7F4A_7C15;

    typedef logic [SLOT_COUNT_LOG2-1:0] slot_idx_t;
    typedef logic [ADDR_W-1:0]          addr_t;

    localparam slot_idx_t SLOT_MASK = slot_idx_t'(SLOT_COUNT - 1);

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    typedef struct packed {
        logic  op;
        addr_t page_addr;
    } vph_cmd_t;

    typedef struct packed {
        logic seen;
        logic table_full;
    } vph_result_t;

endpackage

`default_nettype wire

FILE: hdl/vph_hash.sv
// fibonacci hash of the page number, one 32x32 partial product per cycle
// depends on vph_pkg
`timescale 1ns / 1ps
`default_nettype none

module vph_hash (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              go,
    input  wire vph_pkg::addr_t    page_addr,
    output logic                   done,
    output vph_pkg::slot_idx_t     home_slot
);
    import vph_pkg::*;

    logic [PAGE_W-1:0]   page_reg;
    logic [1:0]          step_reg, step_next;
    logic                run_reg, run_next;
    logic                done_reg, done_next;
    logic [ADDR_W-1:0]   prod_reg;
    logic [ADDR_W-1:0]   acc_reg, acc_next;
    logic [HALF_W-1:0]   mul_a, mul_b;
    logic [ADDR_W-1:0]   mul_p;
    logic [ADDR_W-1:0]   prod_hi;

    // operand schedule: lo*lo, lo*hi, hi*lo; the hi*hi term drops out mod 2^64
    always_comb
    begin
        case (step_reg)
            2'd0:
            begin
                mul_a = page_reg[HALF_W-1:0];
                mul_b = FIB_MULT[HALF_W-1:0];
            end
            2'd1:
            begin
                mul_a = page_reg[HALF_W-1:0];
                mul_b = FIB_MULT[ADDR_W-1:HALF_W];
            end
            2'd2:
            begin
                mul_a = HALF_W'(page_reg[PAGE_W-1:HALF_W]);
                mul_b = FIB_MULT[HALF_W-1:0];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p   = ADDR_W'(mul_a) * ADDR_W'(mul_b);
    assign prod_hi = {prod_reg[HALF_W-1:0], {HALF_W{1'b0}}};

    always_comb
    begin
        step_next = step_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        acc_next  = acc_reg;
        if (go)
        begin
            run_next  = 1'b1;
            step_next = 2'd0;
        end
        else if (run_reg)
        begin
            step_next = step_reg + 2'd1;
            case (step_reg)
                2'd0:    acc_next = acc_reg;
                2'd1:    acc_next = prod_reg;
                2'd2:    acc_next = acc_reg + prod_hi;
                2'd3:
                begin
                    acc_next  = acc_reg + prod_hi;
                    run_next  = 1'b0;
                    done_next = 1'b1;
                end
                default: acc_next = acc_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            page_reg <= page_addr[ADDR_W-1:PAGE_SHIFT];
        end
        prod_reg <= mul_p;
        acc_reg  <= acc_next;
    end

    assign done      = done_reg;
    assign home_slot = acc_reg[HASH_SHIFT +: SLOT_COUNT_LOG2];

endmodule

`default_nettype wire

FILE: hdl/visited_page_hash_set.sv
// visited page hash set top level: slot memory, probe sequencer, clearing pass
// depends on vph_pkg and vph_hash
`timescale 1ns / 1ps
`default_nettype none

// A command is taken when start is high and busy is low; its one result
// appears on result for a single cycle with done high and cannot be held off.
// A test-and-insert runs the hash multiply and then a linear probe from the
// home slot that visits one further slot at a time until a slot decides it or
// the whole table is full, since the slot memory is read once per cycle. A
// clear walks the slot memory one entry per cycle. After reset the block
// runs the same clearing pass with busy high before it takes its first
// command; that pass gives no result.
module visited_page_hash_set (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire vph_pkg::vph_cmd_t     cmd,
    output logic                       done,
    output vph_pkg::vph_result_t       result
);
    import vph_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CLEAR = 4'b0010,
        ST_HASH  = 4'b0100,
        ST_PROBE = 4'b1000
    } state_t;

    state_t      state_reg, state_next;
    slot_idx_t   idx_reg, idx_next;
    slot_idx_t   cnt_reg, cnt_next;
    logic        reply_reg, reply_next;
    logic        done_reg, done_next;
    vph_result_t result_reg, result_next;
    addr_t       addr_reg;

    logic        accept;
    logic        hash_done;
    slot_idx_t   hash_slot;

    addr_t       slot_mem [SLOT_COUNT];
    addr_t       rd_data_reg;
    slot_idx_t   rd_addr;
    logic        mem_we;
    slot_idx_t   wr_addr;
    addr_t       wr_data;

    assign accept = start && !busy;

    vph_hash u_hash (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (accept && (cmd.op == OP_INSERT)),
        .page_addr (cmd.page_addr),
        .done      (hash_done),
        .home_slot (hash_slot)
    );

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        cnt_next    = cnt_reg;
        reply_next  = reply_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        rd_addr     = idx_reg + slot_idx_t'(1);
        mem_we      = 1'b0;
        wr_addr     = idx_reg;
        wr_data     = addr_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd.op == OP_CLEAR)
                    begin
                        state_next = ST_CLEAR;
                        cnt_next   = '0;
                        reply_next = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_HASH;
                    end
                end
            end
            ST_CLEAR:
            begin
                mem_we   = 1'b1;
                wr_addr  = cnt_reg;
                wr_data  = '0;
                cnt_next = cnt_reg + slot_idx_t'(1);
                if (cnt_reg == SLOT_MASK)
                begin
                    state_next  = ST_IDLE;
                    done_next   = reply_reg;
                    result_next = '{seen: 1'b0, table_full: 1'b0};
                    reply_next  = 1'b0;
                end
            end
            ST_HASH:
            begin
                rd_addr = hash_slot;
                if (hash_done)
                begin
                    state_next = ST_PROBE;
                    idx_next   = hash_slot;
                    cnt_next   = '0;
                end
            end
            ST_PROBE:
            begin
                if (rd_data_reg == '0)
                begin
                    mem_we      = 1'b1;
                    state_next  = ST_IDLE;
                    done_next   = 1'b1;
                    result_next = '{seen: 1'b0, table_full: 1'b0};
                end
                else if (rd_data_reg == addr_reg)
                begin
                    state_next  = ST_IDLE;
                    done_next   = 1'b1;
                    result_next = '{seen: 1'b1, table_full: 1'b0};
                end
                else if (cnt_reg == SLOT_MASK)
                begin
                    state_next  = ST_IDLE;
                    done_next   = 1'b1;
                    result_next = '{seen: 1'b1, table_full: 1'b1};
                end
                else
                begin
                    idx_next = idx_reg + slot_idx_t'(1);
                    cnt_next = cnt_reg + slot_idx_t'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            cnt_reg   <= '0;
            reply_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            reply_reg <= reply_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        result_reg <= result_next;
        if (accept)
        begin
            addr_reg <= cmd.page_addr;
        end
    end

    // slot memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= slot_mem[rd_addr];
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(state_reg) == ST_PROBE || $past(state_reg) == ST_CLEAR))
        else $error("result without a finished probe or clear");

    a_full_is_seen: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.table_full) |-> result.seen)
        else $error("full table reported as new");

    a_insert_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PROBE && mem_we) |-> (rd_data_reg == '0))
        else $error("insert overwrote an occupied slot");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("accepted transaction did not raise busy");

    a_probe_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PROBE && !done_next) |=>
            (idx_reg == $past(idx_reg) + slot_idx_t'(1)))
        else $error("probe did not step to the next slot");

endmodule

`default_nettype wire

FILE: dv/visited_page_hash_set_tb.sv
// testbench for visited_page_hash_set: directed cases, long wrapping probe chains and random
// transactions, each result checked against a shadow copy of the slot table
// depends on vph_pkg and the visited_page_hash_set rtl
`timescale 1ns / 1ps

module visited_page_hash_set_tb;
    import vph_pkg::*;

    localparam int QUIET_LIMIT   = 50000;
    localparam int RANDOM_ITEMS  = 1680;
    localparam int RECENT_DEPTH  = 64;
    localparam int CHAIN_ENTRIES = 128;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    vph_cmd_t    cmd   = '0;
    logic        busy;
    logic        done;
    vph_result_t result;

    addr_t       shadow_slots [SLOT_COUNT];
    int          shadow_used;
    vph_result_t pending_verdicts [$];
    vph_result_t oldest_verdict;
    addr_t       recent_pages [$];
    int          sender_idle_pct;
    int          mismatches = 0;
    int          quiet_cycles = 0;

    visited_page_hash_set u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic slot_idx_t page_home(addr_t a);
        addr_t prod;
        prod = (a >> PAGE_SHIFT) * FIB_MULT;
        return prod[HASH_SHIFT +: SLOT_COUNT_LOG2];
    endfunction

    // updates the shadow table and returns the verdict the block owes
    function automatic vph_result_t verdict_for(vph_cmd_t c);
        vph_result_t r;
        slot_idx_t   idx;
        int          n;
        r = '0;
        if (c.op == OP_CLEAR)
        begin
            foreach (shadow_slots[i])
                shadow_slots[i] = '0;
            shadow_used = 0;
            return r;
        end
        idx = page_home(c.page_addr);
        for (n = 0; n < SLOT_COUNT; n++)
        begin
            if (shadow_slots[idx] == '0)
            begin
                // zero is the empty mark, so address zero never takes a slot
                if (c.page_addr != '0)
                begin
                    shadow_slots[idx] = c.page_addr;
                    shadow_used++;
                end
                return r;
            end
            if (shadow_slots[idx] == c.page_addr)
            begin
                r.seen = 1'b1;
                return r;
            end
            idx = idx + slot_idx_t'(1);
        end
        r.seen       = 1'b1;
        r.table_full = 1'b1;
        return r;
    endfunction

    task automatic issue_cmd(input logic op, input addr_t addr);
        vph_cmd_t c;
        int       gap;
        c.op        = op;
        c.page_addr = addr;
        start <= 1'b1;
        cmd   <= c;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        pending_verdicts.push_back(verdict_for(c));
        gap = 0;
        if ($urandom_range(0, 99) < sender_idle_pct)
            gap = $urandom_range(1, 12);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_all_verdicts();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_verdicts.size() != 0);
    endtask

    task automatic test_directed_cases();
        addr_t wrap_addr;
        int    k;
        sender_idle_pct = 0;
        issue_cmd(OP_INSERT, 64'h0000_0000_0000_1000);
        issue_cmd(OP_INSERT, 64'h0000_0000_0000_1000);
        // same page, other low bits: same home slot, separate entry
        issue_cmd(OP_INSERT, 64'h0000_0000_0000_1ABC);
        issue_cmd(OP_INSERT, 64'h0000_0000_0000_1ABC);
        issue_cmd(OP_INSERT, 64'h0000_0000_0000_0FFF);
        issue_cmd(OP_INSERT, '0);
        issue_cmd(OP_INSERT, '0);
        issue_cmd(OP_INSERT, '1);
        issue_cmd(OP_INSERT, '1);
        issue_cmd(OP_INSERT, 64'h8000_0000_0000_0000);
        issue_cmd(OP_INSERT, 64'hFFFF_FFFF_FFFF_F000);
        // three pages on the last slot so the probe wraps to the start
        for (k = 0; k < 3; k++)
        begin
            do
                wrap_addr = {$urandom, $urandom};
            while (wrap_addr == '0 || page_home(wrap_addr) != SLOT_MASK);
            issue_cmd(OP_INSERT, wrap_addr);
        end
        issue_cmd(OP_INSERT, wrap_addr);
        issue_cmd(OP_CLEAR, '1);
        issue_cmd(OP_INSERT, 64'h0000_0000_0000_1000);
        issue_cmd(OP_INSERT, '0);
        issue_cmd(OP_CLEAR, '0);
    endtask

    task automatic test_long_chains();
        addr_t cand;
        addr_t stored;
        sender_idle_pct = 14;
        issue_cmd(OP_CLEAR, '0);
        // pages homed on the last slots pile up into one long chain that wraps
        while (shadow_used < CHAIN_ENTRIES)
        begin
            do
                cand = {$urandom, $urandom};
            while (cand == '0 || page_home(cand) < SLOT_MASK - 15);
            issue_cmd(OP_INSERT, cand);
        end
        stored = shadow_slots[0];
        issue_cmd(OP_INSERT, stored);
        issue_cmd(OP_INSERT, cand);
        issue_cmd(OP_INSERT, {cand[ADDR_W-1:PAGE_SHIFT], ~cand[PAGE_SHIFT-1:0]});
        issue_cmd(OP_INSERT, '0);
        wait_all_verdicts();
        issue_cmd(OP_CLEAR, '0);
        issue_cmd(OP_INSERT, '0);
        issue_cmd(OP_INSERT, stored);
    endtask

    task automatic test_random_mix();
        int    phase;
        int    n;
        int    roll;
        logic  op_sel;
        addr_t pick;
        for (phase = 0; phase < 3; phase++)
        begin
            if (phase == 1)
                sender_idle_pct = 66;
            else if (phase == 2)
                sender_idle_pct = 14;
            else
                sender_idle_pct = 0;
            for (n = 0; n < RANDOM_ITEMS / 3; n++)
            begin
                roll   = $urandom_range(0, 99);
                op_sel = OP_INSERT;
                pick   = {$urandom, $urandom};
                if (roll < 1)
                    op_sel = OP_CLEAR;
                else if (roll < 3)
                    pick = '0;
                else if (roll < 40 && recent_pages.size() != 0)
                    pick = recent_pages[$urandom_range(0, recent_pages.size() - 1)];
                else if (roll < 55 && recent_pages.size() != 0)
                begin
                    pick = recent_pages[$urandom_range(0, recent_pages.size() - 1)];
                    pick[PAGE_SHIFT-1:0] = PAGE_SHIFT'($urandom);
                end
                else if (roll < 65)
                begin
                    // pages near the end of the table, so chains wrap around
                    do
                        pick = {$urandom, $urandom};
                    while (page_home(pick) < SLOT_MASK - 7);
                end
                else if (roll < 80)
                    pick[PAGE_SHIFT-1:0] = '0;
                if (op_sel == OP_INSERT)
                begin
                    recent_pages.push_back(pick);
                    if (recent_pages.size() > RECENT_DEPTH)
                        void'(recent_pages.pop_front());
                end
                issue_cmd(op_sel, pick);
            end
            wait_all_verdicts();
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
        begin
            if (pending_verdicts.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result at %0t: seen %b table_full %b",
                             $time, result.seen, result.table_full);
            end
            else
            begin
                oldest_verdict = pending_verdicts.pop_front();
                if (result.seen !== oldest_verdict.seen ||
                    result.table_full !== oldest_verdict.table_full)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch at %0t: seen exp %b got %b, table_full exp %b got %b",
                                 $time, oldest_verdict.seen, result.seen,
                                 oldest_verdict.table_full, result.table_full);
                end
            end
        end
    end

    // watchdog on cycles with no transaction in either direction
    always @(posedge clk)
    begin
        if ((start && busy === 1'b0) || done === 1'b1)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        foreach (shadow_slots[i])
            shadow_slots[i] = '0;
        shadow_used     = 0;
        sender_idle_pct = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_cases();
        wait_all_verdicts();
        test_long_chains();
        wait_all_verdicts();
        test_random_mix();
        wait_all_verdicts();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && pending_verdicts.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
